// File: rtl/kmu_pkg.sv
// ----------------------------------------------------------------------------
// kmu_pkg
// Types, key positions and layout tables shared by the key matrix scanner.
// ----------------------------------------------------------------------------
package kmu_pkg;

  localparam int unsigned NUM_COLS = 8;
  localparam int unsigned NUM_ROWS = 8;

  // Key positions as {row, mirrored column}
  localparam logic [5:0] POS_LEFT_SHIFT  = 6'o70;
  localparam logic [5:0] POS_RIGHT_SHIFT = 6'o56;
  localparam logic [5:0] POS_CODE        = 6'o72;

  typedef struct packed {
    logic [2:0] row_index;
    logic [7:0] return_levels;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic ls;
    logic rs;
    logic code;
  } mod_t;

  // What one column lane found in the sample
  typedef struct packed {
    logic        changed;
    logic        now;
    logic        is_ls;
    logic        is_rs;
    logic        is_code;
    logic [15:0] code_e;
    logic [15:0] shift_e;
    logic [15:0] plain_e;
    logic [7:0]  fixed_e;
  } lane_info_t;

  // Bytes a column contributes, in order
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } slot_t;

  // Layer entries: zero is no key, above 8'hFF is a two-byte sequence
  function automatic logic [15:0] code_entry(input logic [5:0] pos);
    logic [15:0] e;
    case (pos)
      6'o05: e = 16'h005C;
      6'o26: e = 16'h007E;
      6'o65: e = 16'h003E;
      6'o75: e = 16'h003C;
      6'o66: e = 16'hC2B5;
      6'o34: e = 16'h007C;
      6'o55: e = 16'h0023;
      6'o45: e = 16'h0027;
      6'o25: e = 16'hC2B2;
      6'o35: e = 16'hC2B3;
      6'o03: e = 16'h007B;
      6'o14: e = 16'h005B;
      6'o04: e = 16'h005D;
      6'o15: e = 16'h007D;
      default: e = 16'h0000;
    endcase
    return e;
  endfunction

  // Letters share positions between the shifted and plain layers
  function automatic logic [7:0] letter(input logic [5:0] pos);
    logic [7:0] l;
    case (pos)
      6'o50: l = 8'h41;
      6'o63: l = 8'h42;
      6'o62: l = 8'h43;
      6'o41: l = 8'h44;
      6'o31: l = 8'h45;
      6'o52: l = 8'h46;
      6'o42: l = 8'h47;
      6'o53: l = 8'h48;
      6'o24: l = 8'h49;
      6'o43: l = 8'h4A;
      6'o54: l = 8'h4B;
      6'o44: l = 8'h4C;
      6'o64: l = 8'h4D;
      6'o74: l = 8'h4E;
      6'o34: l = 8'h4F;
      6'o25: l = 8'h50;
      6'o30: l = 8'h51;
      6'o22: l = 8'h52;
      6'o51: l = 8'h53;
      6'o32: l = 8'h54;
      6'o33: l = 8'h55;
      6'o73: l = 8'h56;
      6'o21: l = 8'h57;
      6'o61: l = 8'h58;
      6'o60: l = 8'h59;
      6'o23: l = 8'h5A;
      default: l = 8'h00;
    endcase
    return l;
  endfunction

  function automatic logic [15:0] shift_entry(input logic [5:0] pos);
    logic [15:0] e;
    case (pos)
      6'o00: e = 16'h0021;
      6'o11: e = 16'h0022;
      6'o01: e = 16'hC2A7;
      6'o12: e = 16'h0024;
      6'o02: e = 16'h0025;
      6'o13: e = 16'h0026;
      6'o03: e = 16'h002F;
      6'o14: e = 16'h0028;
      6'o04: e = 16'h0029;
      6'o15: e = 16'h003D;
      6'o05: e = 16'h003F;
      6'o26: e = 16'h002A;
      6'o16: e = 16'h0060;
      6'o65: e = 16'h003A;
      6'o75: e = 16'h003B;
      6'o66: e = 16'h005F;
      6'o55: e = 16'hC396;
      6'o45: e = 16'hC384;
      6'o35: e = 16'hC39C;
      default: e = {8'h00, letter(pos)};
    endcase
    return e;
  endfunction

  function automatic logic [15:0] plain_entry(input logic [5:0] pos);
    logic [15:0] e;
    logic [7:0]  l;
    l = letter(pos);
    case (pos)
      6'o00: e = 16'h0031;
      6'o11: e = 16'h0032;
      6'o01: e = 16'h0033;
      6'o12: e = 16'h0034;
      6'o02: e = 16'h0035;
      6'o13: e = 16'h0036;
      6'o03: e = 16'h0037;
      6'o14: e = 16'h0038;
      6'o04: e = 16'h0039;
      6'o15: e = 16'h0030;
      6'o05: e = 16'hC39F;
      6'o16: e = 16'hC2B4;
      6'o26: e = 16'h002B;
      6'o65: e = 16'h002E;
      6'o75: e = 16'h002C;
      6'o66: e = 16'h002D;
      6'o55: e = 16'hC3B6;
      6'o45: e = 16'hC3A4;
      6'o35: e = 16'hC3BC;
      // lower case is upper case plus 0x20
      default: e = (l == 8'h00) ? 16'h0000 : {8'h00, l | 8'h20};
    endcase
    return e;
  endfunction

  // enter, backspace, space, tab
  function automatic logic [7:0] fixed_entry(input logic [5:0] pos);
    logic [7:0] e;
    case (pos)
      6'o57: e = 8'h0D;
      6'o17: e = 8'h08;
      6'o76: e = 8'h20;
      6'o20: e = 8'h09;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/kmu_lane.sv
// ----------------------------------------------------------------------------
// kmu_lane
// One return column: change detection, modifier decode and layout lookups.
// ----------------------------------------------------------------------------
module kmu_lane (
  input  logic [2:0]          row,
  input  logic [2:0]          col,
  input  logic                now,
  input  logic                was,
  output kmu_pkg::lane_info_t info
);

  logic [5:0] pos;

  // return lines are wired mirrored
  assign pos = {row, ~col};

  always_comb begin
    info.changed = now ^ was;
    info.now     = now;
    info.is_ls   = (pos == kmu_pkg::POS_LEFT_SHIFT);
    info.is_rs   = (pos == kmu_pkg::POS_RIGHT_SHIFT);
    info.is_code = (pos == kmu_pkg::POS_CODE);
    info.code_e  = kmu_pkg::code_entry(pos);
    info.shift_e = kmu_pkg::shift_entry(pos);
    info.plain_e = kmu_pkg::plain_entry(pos);
    info.fixed_e = kmu_pkg::fixed_entry(pos);
  end

endmodule

// File: rtl/kmu_merge.sv
// ----------------------------------------------------------------------------
// kmu_merge
// Walks the lanes in column order, tracks modifiers and forms each
// column's byte slot.
// ----------------------------------------------------------------------------
module kmu_merge (
  input  kmu_pkg::lane_info_t [kmu_pkg::NUM_COLS-1:0] lanes,
  input  kmu_pkg::mod_t                               mod_in,
  output kmu_pkg::slot_t      [kmu_pkg::NUM_COLS-1:0] slots,
  output kmu_pkg::mod_t                               mod_out
);

  always_comb begin
    kmu_pkg::mod_t m;
    logic [15:0]   e;
    logic [7:0]    f;
    m = mod_in;
    for (int c = 0; c < kmu_pkg::NUM_COLS; c++) begin
      e        = '0;
      f        = '0;
      slots[c] = '0;
      if (lanes[c].changed) begin
        if (!lanes[c].now) begin
          if (lanes[c].is_ls)   m.ls   = 1'b0;
          if (lanes[c].is_rs)   m.rs   = 1'b0;
          if (lanes[c].is_code) m.code = 1'b0;
        end else begin
          if (lanes[c].is_ls)   m.ls   = 1'b1;
          if (lanes[c].is_rs)   m.rs   = 1'b1;
          if (lanes[c].is_code) m.code = 1'b1;
          if (m.code)
            e = lanes[c].code_e;
          else if (m.ls || m.rs)
            e = lanes[c].shift_e;
          else
            e = lanes[c].plain_e;
          f = lanes[c].fixed_e;
          // no position has both a two-byte entry and a fixed key
          if (e[15:8] != 8'h00) begin
            slots[c].cnt = 2'd2;
            slots[c].b0  = e[15:8];
            slots[c].b1  = e[7:0];
          end else if (e[7:0] != 8'h00) begin
            slots[c].b0  = e[7:0];
            slots[c].b1  = f;
            slots[c].cnt = (f != 8'h00) ? 2'd2 : 2'd1;
          end else if (f != 8'h00) begin
            slots[c].b0  = f;
            slots[c].cnt = 2'd1;
          end
        end
      end
    end
    mod_out = m;
  end

endmodule

// File: rtl/kmu_emit.sv
// ----------------------------------------------------------------------------
// kmu_emit
// Holds the column slots of one sample and sends their bytes one
// transaction at a time, lowest column first.
// ----------------------------------------------------------------------------
module kmu_emit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    load,
  input  kmu_pkg::slot_t [kmu_pkg::NUM_COLS-1:0]  slots,
  output logic                                    busy,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output kmu_pkg::out_t                           out_data
);

  kmu_pkg::slot_t [kmu_pkg::NUM_COLS-1:0] slots_r;
  logic [kmu_pkg::NUM_COLS-1:0]           mask_r, mask_nxt;
  logic                                   second_r, second_nxt;
  logic [kmu_pkg::NUM_COLS-1:0]           load_mask;
  logic [kmu_pkg::NUM_COLS-1:0]           cur_bit;
  logic [2:0]                             idx;
  logic                                   lane_done;
  kmu_pkg::slot_t                         cur;

  always_comb begin
    idx = '0;
    for (int i = kmu_pkg::NUM_COLS - 1; i >= 0; i--) begin
      if (mask_r[i]) idx = 3'(i);
    end
    for (int i = 0; i < kmu_pkg::NUM_COLS; i++) begin
      load_mask[i] = (slots[i].cnt != 2'd0);
    end
  end

  assign cur       = slots_r[idx];
  assign cur_bit   = kmu_pkg::NUM_COLS'(1) << idx;
  assign lane_done = second_r || (cur.cnt == 2'd1);
  assign busy      = |mask_r;
  assign out_valid = busy;

  always_comb begin
    out_data.out_byte = second_r ? cur.b1 : cur.b0;
    out_data.last     = lane_done && ((mask_r & ~cur_bit) == '0);
  end

  always_comb begin
    mask_nxt   = mask_r;
    second_nxt = second_r;
    if (load) begin
      mask_nxt   = load_mask;
      second_nxt = 1'b0;
    end else if (out_valid && out_ready) begin
      if (lane_done) begin
        mask_nxt   = mask_r & ~cur_bit;
        second_nxt = 1'b0;
      end else begin
        second_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      second_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= slots;
    end
  end

`ifndef SYNTH
  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (mask_r == '0))
    else $error("sample loaded while bytes still pending");

  a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && second_r) |-> (cur.cnt == 2'd2))
    else $error("second byte sent from a single-byte column");

  a_last_single_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> ($countones(mask_r) == 1))
    else $error("last flagged with further columns pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> !out_valid)
    else $error("bytes continue after the last transaction");
`endif

endmodule

// File: rtl/key_matrix_to_utf8.sv
// ----------------------------------------------------------------------------
// key_matrix_to_utf8
// 8x8 key matrix row samples in, UTF-8 bytes of the typed keys out.
// ----------------------------------------------------------------------------
// A row sample is taken when in_valid and in_ready are both high: eight column
// lanes compare it with the stored key state, look up the layouts and the
// modifier chain is resolved in column order. The bytes then leave one per
// cycle through the single output port while out_ready is high; a sample gives
// 0 to 16 bytes, and in_ready is low while bytes are pending.
// The key store and modifiers are cleared by reset, no clearing pass needed.
module key_matrix_to_utf8 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kmu_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kmu_pkg::out_t  out_data
);

  logic [kmu_pkg::NUM_COLS-1:0]               key_down_r [kmu_pkg::NUM_ROWS];
  kmu_pkg::mod_t                              mod_r, mod_nxt;
  logic [kmu_pkg::NUM_COLS-1:0]               pressed, was_row;
  kmu_pkg::lane_info_t [kmu_pkg::NUM_COLS-1:0] lanes;
  kmu_pkg::slot_t      [kmu_pkg::NUM_COLS-1:0] slots;
  logic                                       in_fire;
  logic                                       busy;

  assign pressed  = ~in_data.return_levels;
  assign was_row  = key_down_r[in_data.row_index];
  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  for (genvar c = 0; c < kmu_pkg::NUM_COLS; c++) begin : g_lane
    kmu_lane u_lane (
      .row  (in_data.row_index),
      .col  (3'(c)),
      .now  (pressed[c]),
      .was  (was_row[c]),
      .info (lanes[c])
    );
  end

  kmu_merge u_merge (
    .lanes   (lanes),
    .mod_in  (mod_r),
    .slots   (slots),
    .mod_out (mod_nxt)
  );

  kmu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .slots     (slots),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
      for (int r = 0; r < kmu_pkg::NUM_ROWS; r++) begin
        key_down_r[r] <= '0;
      end
    end else if (in_fire) begin
      mod_r                         <= mod_nxt;
      key_down_r[in_data.row_index] <= pressed;
    end
  end

endmodule
